// File: hw/rtl/smbd_pkg.sv
// Shared types and constants for the segmented memory bus decoder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package smbd_pkg;

	localparam int ADDR_W = 32;
	localparam int DATA_W = 32;

	// default store sizes in bytes
	localparam int RAM_BYTES_DEF     = 2097152;
	localparam int SCRATCH_BYTES_DEF = 1024;
	localparam int IO_BYTES_DEF      = 8192;
	localparam int ROM_BYTES_DEF     = 524288;
	localparam int CCR_BYTES         = 4;

	// address match patterns
	localparam logic [ADDR_W-1:0] SEG_RAM_MASK  = 32'h1FE0_0000;
	localparam logic [ADDR_W-1:0] SCR_MASK      = 32'h1FFF_FC00;
	localparam logic [ADDR_W-1:0] SCR_BASE      = 32'h1F80_0000;
	localparam logic [ADDR_W-1:0] IO_MASK       = 32'h1FFF_F000;
	localparam logic [ADDR_W-1:0] IO_PAGE1_BASE = 32'h1F80_1000;
	localparam logic [ADDR_W-1:0] IO_PAGE2_BASE = 32'h1F80_2000;
	localparam logic [ADDR_W-1:0] ROM_MASK      = 32'h1FF8_0000;
	localparam logic [ADDR_W-1:0] ROM_BASE      = 32'h1FC0_0000;
	localparam logic [ADDR_W-1:0] CCR_ADDRESS   = 32'hFFFE_0130;

	// access codes
	localparam logic       ACT_WRITE = 1'b1;
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_UNMAPPED = 2'd1,
		STAT_PAST_END = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_NONE,
		REG_RAM,
		REG_SCR,
		REG_IO,
		REG_ROM,
		REG_CCR
	} region_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;    // zero one row of every store
		logic capture;  // take the request into the first stage
		logic access;   // perform the memory read or write
		logic load;     // load the result register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/smbd_req_if.sv
// Request channel of the bus decoder: valid/ready plus one bus access.
// Depends on smbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface smbd_req_if;
	import smbd_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [1:0]        access_size;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;
	logic              isolate_cache;

	modport source (
		output valid, action, access_size, address, write_data, isolate_cache,
		input  ready
	);

	modport sink (
		input  valid, action, access_size, address, write_data, isolate_cache,
		output ready
	);

endinterface

`default_nettype wire

// File: hw/rtl/smbd_rsp_if.sv
// Response channel of the bus decoder: valid/ready plus read data and status.
// Depends on smbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface smbd_rsp_if;
	import smbd_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic [1:0]        status;

	modport source (
		output valid, read_data, status,
		input  ready
	);

	modport sink (
		input  valid, read_data, status,
		output ready
	);

endinterface

`default_nettype wire

// File: hw/rtl/smbd_ctrl.sv
// Controller of the bus decoder: clear sweep, request/response handshakes.
// Depends on smbd_pkg; drives smbd_dp through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module smbd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output smbd_pkg::dp_cmd_t      cmd,
	input  wire smbd_pkg::dp_stat_t stat,
	output smbd_pkg::state_t       state
);
	import smbd_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				cmd.access = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				// wait for a free result slot
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase

		if (cmd.load)
			out_valid_d = 1'b1;
		else if (out_ready)
			out_valid_d = 1'b0;
		else
			out_valid_d = out_valid_q;
	end

	assign out_valid = out_valid_q;
	assign state     = state_q;

endmodule

`default_nettype wire

// File: hw/rtl/smbd_dp.sv
// Datapath of the bus decoder: address decode, four byte-lane banks per store,
// cache control word, result assembly and result register. Depends on smbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smbd_dp #(
	parameter int RAM_BYTES     = smbd_pkg::RAM_BYTES_DEF,
	parameter int SCRATCH_BYTES = smbd_pkg::SCRATCH_BYTES_DEF,
	parameter int IO_BYTES      = smbd_pkg::IO_BYTES_DEF,
	parameter int ROM_BYTES     = smbd_pkg::ROM_BYTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire smbd_pkg::dp_cmd_t           cmd,
	output smbd_pkg::dp_stat_t               stat,
	input  wire logic                        action,
	input  wire logic [1:0]                  access_size,
	input  wire logic [smbd_pkg::ADDR_W-1:0] address,
	input  wire logic [smbd_pkg::DATA_W-1:0] write_data,
	input  wire logic                        isolate_cache,
	output logic [smbd_pkg::DATA_W-1:0]      read_data,
	output logic [1:0]                       status
);
	import smbd_pkg::*;

	localparam int MAX_A     = (RAM_BYTES > ROM_BYTES) ? RAM_BYTES : ROM_BYTES;
	localparam int MAX_B     = (IO_BYTES > SCRATCH_BYTES) ? IO_BYTES : SCRATCH_BYTES;
	localparam int MAX_BYTES = (MAX_A > MAX_B) ? MAX_A : MAX_B;
	localparam int OFF_W     = $clog2(MAX_BYTES);
	localparam int ROW_W     = OFF_W - 2;

	localparam int RAM_AW = $clog2(RAM_BYTES);
	localparam int SCR_AW = $clog2(SCRATCH_BYTES);
	localparam int IO_AW  = $clog2(IO_BYTES);
	localparam int ROM_AW = $clog2(ROM_BYTES);

	localparam int IO_PAGE_BYTES = IO_BYTES / 2;

	localparam int RAM_ROWS = RAM_BYTES / 4;
	localparam int SCR_ROWS = SCRATCH_BYTES / 4;
	localparam int IO_ROWS  = IO_BYTES / 4;
	localparam int ROM_ROWS = ROM_BYTES / 4;
	localparam int CLR_ROWS = MAX_BYTES / 4;

	localparam int RAM_RW = $clog2(RAM_ROWS);
	localparam int SCR_RW = $clog2(SCR_ROWS);
	localparam int IO_RW  = $clog2(IO_ROWS);
	localparam int ROM_RW = $clog2(ROM_ROWS);
	localparam int CLR_W  = $clog2(CLR_ROWS);

	// request stage
	logic              action_s1;
	logic [1:0]        size_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] wdata_s1;
	logic              iso_s1;

	// memory stage
	region_t    region_s2;
	status_t    status_s2;
	logic [1:0] base_s2;
	logic [2:0] len_s2;
	logic       write_s2;

	logic [CLR_W-1:0]  clr_cnt_q;
	logic [DATA_W-1:0] ccr_q;
	logic [DATA_W-1:0] rdata_q;
	status_t           status_q;

	region_t          region;
	logic [OFF_W-1:0] off;
	logic [OFF_W:0]   store_bytes;
	logic [OFF_W:0]   end_off;
	logic [2:0]       len;
	status_t          acc_status;
	logic             do_write;
	logic [DATA_W-1:0] rd_word;
	logic [7:0]       lane_rd [4];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_s1 <= action;
			size_s1   <= access_size;
			addr_s1   <= address;
			wdata_s1  <= write_data;
			iso_s1    <= isolate_cache;
		end
	end

	// decode, first match wins
	always_comb begin
		region      = REG_NONE;
		off         = '0;
		store_bytes = '0;
		if ((addr_s1 & SEG_RAM_MASK) == '0) begin
			if (iso_s1) begin
				region      = REG_SCR;
				off         = OFF_W'(addr_s1[SCR_AW-1:0]);
				store_bytes = (OFF_W+1)'(SCRATCH_BYTES);
			end else begin
				region      = REG_RAM;
				off         = OFF_W'(addr_s1[RAM_AW-1:0]);
				store_bytes = (OFF_W+1)'(RAM_BYTES);
			end
		end else if ((addr_s1 & SCR_MASK) == SCR_BASE) begin
			region      = REG_SCR;
			off         = OFF_W'(addr_s1[SCR_AW-1:0]);
			store_bytes = (OFF_W+1)'(SCRATCH_BYTES);
		end else if ((addr_s1 & IO_MASK) == IO_PAGE1_BASE) begin
			region      = REG_IO;
			off         = OFF_W'(addr_s1[IO_AW-2:0]);
			store_bytes = (OFF_W+1)'(IO_BYTES);
		end else if ((addr_s1 & IO_MASK) == IO_PAGE2_BASE) begin
			region      = REG_IO;
			off         = OFF_W'(IO_PAGE_BYTES) + OFF_W'(addr_s1[IO_AW-2:0]);
			store_bytes = (OFF_W+1)'(IO_BYTES);
		end else if ((addr_s1 & ROM_MASK) == ROM_BASE) begin
			region      = REG_ROM;
			off         = OFF_W'(addr_s1[ROM_AW-1:0]);
			store_bytes = (OFF_W+1)'(ROM_BYTES);
		end else if (addr_s1 == CCR_ADDRESS) begin
			region      = REG_CCR;
			store_bytes = (OFF_W+1)'(CCR_BYTES);
		end

		case (size_s1)
			SIZE_BYTE: len = 3'd1;
			SIZE_HALF: len = 3'd2;
			default:   len = 3'd4;   // word, and the unused code
		endcase

		end_off = (OFF_W+1)'(off) + (OFF_W+1)'(len);

		if (region == REG_NONE)
			acc_status = STAT_UNMAPPED;
		else if (end_off > store_bytes)
			acc_status = STAT_PAST_END;
		else
			acc_status = STAT_OK;
	end

	assign do_write = cmd.access && (action_s1 == ACT_WRITE) && (acc_status == STAT_OK);

	// clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (cmd.clear)
			clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	assign stat.clear_last = (clr_cnt_q == CLR_W'(CLR_ROWS - 1));

	// cache control word, always at offset 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccr_q <= '0;
		end else begin
			for (int i = 0; i < CCR_BYTES; i++) begin
				if (do_write && (region == REG_CCR) && (3'(i) < len))
					ccr_q[8*i +: 8] <= wdata_s1[8*i +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.access) begin
			region_s2 <= region;
			status_s2 <= acc_status;
			base_s2   <= off[1:0];
			len_s2    <= len;
			write_s2  <= (action_s1 == ACT_WRITE);
		end
	end

	// byte lane k holds the bytes whose offset mod 4 is k
	for (genvar k = 0; k < 4; k++) begin : g_lane
		logic [1:0]       byte_idx;
		logic             used;
		logic [ROW_W-1:0] row;
		logic [7:0]       wbyte;
		logic [7:0]       wd;

		logic [RAM_RW-1:0] ram_idx;
		logic [SCR_RW-1:0] scr_idx;
		logic [IO_RW-1:0]  io_idx;
		logic [ROM_RW-1:0] rom_idx;
		logic ram_we, scr_we, io_we, rom_we;
		logic [7:0] ram_rd, scr_rd, io_rd, rom_rd;

		logic [7:0] ram_mem [RAM_ROWS];
		logic [7:0] scr_mem [SCR_ROWS];
		logic [7:0] io_mem  [IO_ROWS];
		logic [7:0] rom_mem [ROM_ROWS];

		assign byte_idx = 2'(k) - off[1:0];
		assign used     = ({1'b0, byte_idx} < len);
		assign row      = off[OFF_W-1:2] + ROW_W'(2'(k) < off[1:0]);
		assign wbyte    = wdata_s1[8*byte_idx +: 8];
		assign wd       = cmd.clear ? 8'h00 : wbyte;

		assign ram_idx = cmd.clear ? RAM_RW'(clr_cnt_q) : row[RAM_RW-1:0];
		assign scr_idx = cmd.clear ? SCR_RW'(clr_cnt_q) : row[SCR_RW-1:0];
		assign io_idx  = cmd.clear ? IO_RW'(clr_cnt_q)  : row[IO_RW-1:0];
		assign rom_idx = cmd.clear ? ROM_RW'(clr_cnt_q) : row[ROM_RW-1:0];

		assign ram_we = cmd.clear ? ({1'b0, clr_cnt_q} < (CLR_W+1)'(RAM_ROWS))
		                          : (do_write && used && (region == REG_RAM));
		assign scr_we = cmd.clear ? ({1'b0, clr_cnt_q} < (CLR_W+1)'(SCR_ROWS))
		                          : (do_write && used && (region == REG_SCR));
		assign io_we  = cmd.clear ? ({1'b0, clr_cnt_q} < (CLR_W+1)'(IO_ROWS))
		                          : (do_write && used && (region == REG_IO));
		assign rom_we = cmd.clear ? ({1'b0, clr_cnt_q} < (CLR_W+1)'(ROM_ROWS))
		                          : (do_write && used && (region == REG_ROM));

		always_ff @(posedge clk) begin
			if (ram_we)
				ram_mem[ram_idx] <= wd;
			ram_rd <= ram_mem[ram_idx];
		end

		always_ff @(posedge clk) begin
			if (scr_we)
				scr_mem[scr_idx] <= wd;
			scr_rd <= scr_mem[scr_idx];
		end

		always_ff @(posedge clk) begin
			if (io_we)
				io_mem[io_idx] <= wd;
			io_rd <= io_mem[io_idx];
		end

		always_ff @(posedge clk) begin
			if (rom_we)
				rom_mem[rom_idx] <= wd;
			rom_rd <= rom_mem[rom_idx];
		end

		always_comb begin
			case (region_s2)
				REG_RAM: lane_rd[k] = ram_rd;
				REG_SCR: lane_rd[k] = scr_rd;
				REG_IO:  lane_rd[k] = io_rd;
				REG_ROM: lane_rd[k] = rom_rd;
				REG_CCR: lane_rd[k] = ccr_q[8*k +: 8];
				default: lane_rd[k] = 8'h00;
			endcase
		end
	end

	// rotate lanes back into access byte order, zero-extend
	always_comb begin
		logic [1:0] lane_sel;
		rd_word  = '0;
		lane_sel = '0;
		for (int i = 0; i < 4; i++) begin
			lane_sel = base_s2 + 2'(i);
			if (3'(i) < len_s2)
				rd_word[8*i +: 8] = lane_rd[lane_sel];
		end
		if (write_s2 || (status_s2 != STAT_OK))
			rd_word = '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rdata_q  <= rd_word;
			status_q <= status_s2;
		end
	end

	assign read_data = rdata_q;
	assign status    = status_q;

endmodule

`default_nettype wire

// File: hw/rtl/segmented_memory_bus_decoder.sv
// Top level of the segmented memory bus decoder: controller, datapath, checks.
// Depends on smbd_pkg, smbd_req_if, smbd_rsp_if, smbd_ctrl and smbd_dp.
`timescale 1ns / 1ps
`default_nettype none

// Decodes one bus access per request transfer into main RAM (or the scratchpad
// while isolate_cache is set), the scratchpad, two I/O pages, boot ROM or the
// cache control word at 0xFFFE0130, and reads or writes 1, 2 or 4 little-endian
// bytes there. Each request gives exactly one response transfer: read data
// zero-extended (zero for writes and errors) and a status of ok, unmapped
// address, or access past the end of the region. Every store is split into
// four byte-lane banks so that a misaligned halfword or word, which may span
// two rows, still needs one read or write per bank. After the request transfer
// an access passes capture at the transfer edge, the lane memory ports
// (registered read) and the result register, where response valid rises; the
// result load waits while an earlier response is still unaccepted. A new
// request can be taken from the cycle after the result is loaded, so the block
// finishes one access before it takes the next. A response waiting in the
// result register does not hold off the next request. After reset the block
// clears all stores, one row of each bank per cycle until that bank is done,
// sweeping max(RAM, ROM, I/O, scratchpad bytes)/4 rows (524288 with default
// sizes); req.ready stays low during that sweep.
module segmented_memory_bus_decoder #(
	parameter int RAM_BYTES     = smbd_pkg::RAM_BYTES_DEF,
	parameter int SCRATCH_BYTES = smbd_pkg::SCRATCH_BYTES_DEF,
	parameter int IO_BYTES      = smbd_pkg::IO_BYTES_DEF,
	parameter int ROM_BYTES     = smbd_pkg::ROM_BYTES_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	smbd_req_if.sink   req,
	smbd_rsp_if.source rsp
);
	import smbd_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	state_t   state;

	// sequencing: clear sweep, accept, memory cycle, result load
	smbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat),
		.state     (state)
	);

	// decode, lane banks and result register
	smbd_dp #(
		.RAM_BYTES     (RAM_BYTES),
		.SCRATCH_BYTES (SCRATCH_BYTES),
		.IO_BYTES      (IO_BYTES),
		.ROM_BYTES     (ROM_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.action        (req.action),
		.access_size   (req.access_size),
		.address       (req.address),
		.write_data    (req.write_data),
		.isolate_cache (req.isolate_cache),
		.read_data     (rsp.read_data),
		.status        (rsp.status)
	);

	// one access in flight: no request right after a transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while an access is in flight");

	// after a request transfer the access state comes first, then the result stage
	a_done_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> ##1 (state == ST_DONE))
		else $error("access did not reach the result stage on time");

	// nothing enters or leaves during the clear sweep
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state == ST_CLEAR) |-> (!req.ready && !rsp.valid))
		else $error("traffic during the clear sweep");

	// failed accesses return zero data
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != STAT_OK)) |-> (rsp.read_data == '0))
		else $error("nonzero read data on an error response");

endmodule

`default_nettype wire

// File: test/tb_smbd_scoreboard_pkg.sv
// Scoreboard for the bus decoder testbench: byte model of every store,
// queue of expected responses, field checks. Depends on smbd_pkg.
`timescale 1ns / 1ps

package smbd_tb_pkg;
	import smbd_pkg::*;

	typedef struct {
		logic [DATA_W-1:0] read_data;
		status_t           status;
	} bus_response_t;

	class bus_map_scoreboard;
		// keyed by {region, offset}; a missing key reads as the reset value, zero
		logic [7:0]    mem_bytes[logic [31:0]];
		bus_response_t expected_responses[$];
		int unsigned   n_reads = 0;
		int unsigned   n_writes = 0;
		int unsigned   n_unmapped = 0;
		int unsigned   n_past_end = 0;
		int unsigned   mismatches = 0;

		function void decode_address(input logic [ADDR_W-1:0] addr, input logic iso,
				output region_t rgn, output int unsigned offset, output int unsigned span);
			rgn = REG_NONE;
			offset = 0;
			span = 0;
			if ((addr & SEG_RAM_MASK) == '0) begin
				if (iso) begin
					rgn = REG_SCR;
					offset = addr & (SCRATCH_BYTES_DEF - 1);
					span = SCRATCH_BYTES_DEF;
				end else begin
					rgn = REG_RAM;
					offset = addr & (RAM_BYTES_DEF - 1);
					span = RAM_BYTES_DEF;
				end
			end else if ((addr & SCR_MASK) == SCR_BASE) begin
				rgn = REG_SCR;
				offset = addr & (SCRATCH_BYTES_DEF - 1);
				span = SCRATCH_BYTES_DEF;
			end else if ((addr & IO_MASK) == IO_PAGE1_BASE) begin
				rgn = REG_IO;
				offset = addr & (IO_BYTES_DEF / 2 - 1);
				span = IO_BYTES_DEF;
			end else if ((addr & IO_MASK) == IO_PAGE2_BASE) begin
				// second page sits in the upper half of the same store
				rgn = REG_IO;
				offset = IO_BYTES_DEF / 2 + (addr & (IO_BYTES_DEF / 2 - 1));
				span = IO_BYTES_DEF;
			end else if ((addr & ROM_MASK) == ROM_BASE) begin
				rgn = REG_ROM;
				offset = addr & (ROM_BYTES_DEF - 1);
				span = ROM_BYTES_DEF;
			end else if (addr == CCR_ADDRESS) begin
				rgn = REG_CCR;
				span = CCR_BYTES;
			end
		endfunction

		function logic [31:0] byte_key(region_t rgn, int unsigned offset);
			return {rgn, 29'(offset)};
		endfunction

		// Accepted request: update the store model and queue the response it must give.
		function void note_request(logic act, logic [1:0] sz, logic [ADDR_W-1:0] addr,
				logic [DATA_W-1:0] wdata, logic iso);
			region_t       rgn;
			int unsigned   offset;
			int unsigned   span;
			int unsigned   len;
			logic [31:0]   key;
			bus_response_t resp;
			len = (sz == SIZE_BYTE) ? 1 : (sz == SIZE_HALF) ? 2 : 4;
			decode_address(addr, iso, rgn, offset, span);
			resp.read_data = '0;
			resp.status = STAT_OK;
			if (rgn == REG_NONE) begin
				resp.status = STAT_UNMAPPED;
				n_unmapped++;
			end else if (offset + len > span) begin
				resp.status = STAT_PAST_END;
				n_past_end++;
			end else if (act == ACT_WRITE) begin
				for (int i = 0; i < len; i++)
					mem_bytes[byte_key(rgn, offset + i)] = wdata[8*i +: 8];
				n_writes++;
			end else begin
				for (int i = 0; i < len; i++) begin
					key = byte_key(rgn, offset + i);
					resp.read_data[8*i +: 8] = mem_bytes.exists(key) ? mem_bytes[key] : 8'h00;
				end
				n_reads++;
			end
			expected_responses.push_back(resp);
		endfunction

		function void check_response(logic [DATA_W-1:0] rdata, logic [1:0] stat);
			bus_response_t want;
			if (expected_responses.size() == 0) begin
				$error("response with no request outstanding: read_data %h status %0d",
					rdata, stat);
				mismatches++;
				return;
			end
			want = expected_responses.pop_front();
			if (rdata !== want.read_data) begin
				$error("read_data: expected %h, got %h", want.read_data, rdata);
				mismatches++;
			end
			if (stat !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, stat);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// File: test/tb_top.sv
// Top-level testbench of segmented_memory_bus_decoder: stimulus, handshake drivers,
// monitors and watchdog. Depends on smbd_pkg, both channel interfaces and smbd_tb_pkg.
`timescale 1ns / 1ps

// Flow of the run:
//  - reset, then wait out the clearing sweep (req.ready low)
//  - directed accesses: segment aliases, misaligned spans, region ends,
//    isolate-cache redirection, I/O page crossing, boot ROM and cache
//    control writes, the unused size code, unmapped addresses
//  - three random phases with different idle mixes on the two sides;
//    the last phase also holds off responses long enough to back up the block
// Every request transfer is predicted by the scoreboard at the clock edge it is
// taken; every response transfer is checked against the oldest prediction.
module tb_top;
	import smbd_pkg::*;
	import smbd_tb_pkg::*;

	localparam logic       ACT_READ  = ~ACT_WRITE;
	localparam logic [1:0] SIZE_WORD = 2'd2;
	localparam logic [1:0] SIZE_WIDE = 2'd3;   // unused code, handled as a word

	// Longest legal quiet stretch is the clearing sweep after
	// reset; allow about three times that before declaring a hang.
	localparam int unsigned STALL_LIMIT     = 1_600_000;
	localparam int unsigned HOLDOFF_CYCLES  = 500;
	localparam int unsigned ITEMS_PER_PHASE = 375;
	localparam int unsigned SETTLE_CYCLES   = 12;
	localparam int unsigned RECENT_DEPTH    = 48;

	logic clk;
	logic arst_n;

	smbd_req_if req_ch();
	smbd_rsp_if rsp_ch();

	segmented_memory_bus_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bus_map_scoreboard sb = new();

	int unsigned sender_idle_pct   = 9;
	int unsigned receiver_idle_pct = 62;
	logic        holdoff_armed     = 1'b0;
	logic        rsp_holdoff       = 1'b0;
	int unsigned quiet_cycles      = 0;
	logic [32:0] recent_locs[$];   // {isolate_cache, address} of mapped accesses

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Response side: random back-pressure, or a solid hold-off when asked.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= !rsp_holdoff && ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	// Long hold-off, timed here while the sender keeps offering requests.
	initial begin
		wait (holdoff_armed);
		rsp_holdoff = 1'b1;
		repeat (HOLDOFF_CYCLES) @(posedge clk);
		rsp_holdoff = 1'b0;
	end

	// Monitors sample at the rising edge; inputs only move on the falling edge.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
			sb.note_request(req_ch.action, req_ch.access_size, req_ch.address,
				req_ch.write_data, req_ch.isolate_cache);
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			sb.check_response(rsp_ch.read_data, rsp_ch.status);
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// Offer one request, with random idle cycles first; returns at the falling
	// edge after the transfer. Valid stays high between back-to-back requests.
	task automatic send_access(logic act, logic [1:0] sz, logic [ADDR_W-1:0] addr,
			logic [DATA_W-1:0] wdata, logic iso);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.action        <= act;
		req_ch.access_size   <= sz;
		req_ch.address       <= addr;
		req_ch.write_data    <= wdata;
		req_ch.isolate_cache <= iso;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		@(negedge clk);
	endtask

	// Offset inside a store: often just below its end (past-end cases), often
	// in a small window at the start (so reads find earlier writes).
	function automatic int unsigned pick_offset(int unsigned span);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 20)
			return span - $urandom_range(1, 6);
		if (roll < 50)
			return $urandom_range(0, 63);
		return $urandom_range(0, span - 1);
	endfunction

	task automatic send_random_access();
		logic              act;
		logic [1:0]        sz;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
		logic              iso;
		logic [ADDR_W-1:0] seg;
		int unsigned       off;
		int unsigned       pick;
		act   = 1'($urandom_range(0, 1));
		sz    = 2'($urandom_range(0, 3));
		wdata = $urandom;
		iso   = ($urandom_range(0, 99) < 15);
		seg   = {3'($urandom_range(0, 7)), 29'b0};   // kuseg/kseg0/kseg1/kseg2 aliases
		pick  = $urandom_range(0, 99);
		if (pick < 35 && recent_locs.size() != 0) begin
			{iso, addr} = recent_locs[$urandom_range(0, recent_locs.size() - 1)];
		end else begin
			if (pick < 55) begin
				addr = seg | pick_offset(RAM_BYTES_DEF);
			end else if (pick < 65) begin
				addr = seg | SCR_BASE | pick_offset(SCRATCH_BYTES_DEF);
			end else if (pick < 75) begin
				off  = pick_offset(IO_BYTES_DEF);
				addr = seg | ((off < IO_BYTES_DEF / 2) ? IO_PAGE1_BASE : IO_PAGE2_BASE)
					| (off & ~IO_MASK);
			end else if (pick < 87) begin
				addr = seg | ROM_BASE | pick_offset(ROM_BYTES_DEF);
			end else if (pick < 91) begin
				addr = CCR_ADDRESS;
			end else if (pick < 95) begin
				// just above the second I/O page: unmapped
				addr = seg | (IO_PAGE2_BASE + 32'h1000) | ($urandom & 32'h000F_FFFF);
			end else begin
				addr = $urandom;
			end
			if (pick < 91) begin
				recent_locs.push_back({iso, addr});
				if (recent_locs.size() > RECENT_DEPTH)
					void'(recent_locs.pop_front());
			end
		end
		send_access(act, sz, addr, wdata, iso);
	endtask

	initial begin
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.action        = ACT_READ;
		req_ch.access_size   = SIZE_BYTE;
		req_ch.address       = '0;
		req_ch.write_data    = '0;
		req_ch.isolate_cache = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part (first idle mix). Stores start out zero.
		send_access(ACT_READ,  SIZE_WORD, 32'h0000_0000, 32'h0, 1'b0);
		send_access(ACT_WRITE, SIZE_WORD, 32'h0000_0000, 32'hDEAD_BEEF, 1'b0);
		send_access(ACT_READ,  SIZE_WORD, 32'h8000_0000, 32'h0, 1'b0);   // kseg0 alias
		send_access(ACT_READ,  SIZE_BYTE, 32'hA000_0001, 32'h0, 1'b0);   // kseg1 alias
		send_access(ACT_READ,  SIZE_HALF, 32'h0000_0003, 32'h0, 1'b0);   // misaligned
		// RAM end: halfword fits, word runs past, unused size code at last word
		send_access(ACT_WRITE, SIZE_HALF, 32'h001F_FFFE, 32'hFFFF_1234, 1'b0);
		send_access(ACT_READ,  SIZE_WORD, 32'h001F_FFFE, 32'h0, 1'b0);
		send_access(ACT_READ,  SIZE_WIDE, 32'h001F_FFFC, 32'h0, 1'b0);
		// cache isolation sends RAM-segment accesses to the scratchpad
		send_access(ACT_WRITE, SIZE_BYTE, 32'h0000_0010, 32'hFFFF_FFA5, 1'b1);
		send_access(ACT_READ,  SIZE_BYTE, 32'h1F80_0010, 32'h0, 1'b0);
		send_access(ACT_READ,  SIZE_BYTE, 32'h0000_0010, 32'h0, 1'b0);
		send_access(ACT_WRITE, SIZE_WORD, 32'h1F80_03FC, 32'hFFFF_FFFF, 1'b0);
		send_access(ACT_READ,  SIZE_WORD, 32'h1F80_03FD, 32'h0, 1'b0);   // past end
		// I/O: a word straddling page 1 into page 2, then page 2 end
		send_access(ACT_WRITE, SIZE_WORD, 32'h1F80_1FFE, 32'h0102_0304, 1'b0);
		send_access(ACT_READ,  SIZE_HALF, 32'h1F80_2000, 32'h0, 1'b0);
		send_access(ACT_READ,  SIZE_WORD, 32'h1F80_2FFD, 32'h0, 1'b0);
		send_access(ACT_WRITE, SIZE_BYTE, 32'h1F80_2FFF, 32'h0000_0077, 1'b0);
		// boot ROM is writable
		send_access(ACT_WRITE, SIZE_WORD, 32'hBFC7_FFFC, 32'hCAFE_F00D, 1'b0);
		send_access(ACT_READ,  SIZE_HALF, 32'h9FC7_FFFE, 32'h0, 1'b0);
		send_access(ACT_READ,  SIZE_WORD, 32'h1FC7_FFFE, 32'h0, 1'b0);
		// cache control word
		send_access(ACT_WRITE, SIZE_WORD, CCR_ADDRESS, 32'h0001_E988, 1'b0);
		send_access(ACT_READ,  SIZE_BYTE, CCR_ADDRESS, 32'h0, 1'b0);
		send_access(ACT_READ,  SIZE_WIDE, CCR_ADDRESS, 32'h0, 1'b1);
		// unmapped
		send_access(ACT_READ,  SIZE_WORD, 32'h0020_0000, 32'h0, 1'b0);
		send_access(ACT_WRITE, SIZE_WORD, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0);

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					sender_idle_pct   = 9;
					receiver_idle_pct = 62;
				end
				1: begin
					sender_idle_pct   = 62;
					receiver_idle_pct = 9;
				end
				default: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == 2 && n == 40)
					holdoff_armed = 1'b1;
				send_random_access();
			end
		end
		req_ch.valid <= 1'b0;

		// drain; the watchdog covers a response that never comes
		while (sb.expected_responses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d accesses: %0d reads and %0d writes in range, %0d unmapped, %0d past region end",
			sb.n_reads + sb.n_writes + sb.n_unmapped + sb.n_past_end,
			sb.n_reads, sb.n_writes, sb.n_unmapped, sb.n_past_end);
		$display("Idle mixes 9/62, 62/9, 0/0 percent (request/response), one %0d-cycle response hold-off",
			HOLDOFF_CYCLES);
		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
